/* rtl/shtqp_pkg.sv */
package shtqp_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned KeyChars   = 20;

  localparam int unsigned SizeW  = 7;
  localparam int unsigned MultW  = 32;
  localparam int unsigned HashW  = 32;
  localparam int unsigned CharW  = 7;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgTableSize = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgHashMult  = 1'd1;

  localparam logic [StatW-1:0] StInserted = 3'd0;
  localparam logic [StatW-1:0] StFound    = 3'd1;
  localparam logic [StatW-1:0] StNotFound = 3'd2;
  localparam logic [StatW-1:0] StFull     = 3'd3;
  localparam logic [StatW-1:0] StTooLong  = 3'd4;

  localparam logic OpInsert = 1'b0;
  localparam logic OpSearch = 1'b1;

endpackage

/* rtl/shtqp_mod.sv */
// sequential remainder: dividend mod divisor, one bit per cycle
module shtqp_mod #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [DenW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  assign trial  = {rem_q, num_q[NumW-1]};
  assign rem_o  = rem_q;
  assign done_o = done_q;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = DenW'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[DenW-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

/* rtl/string_hash_table_quadratic_probe_top.sv */
// a character that is not last is taken in S_CHAR; a last character starts
// the hash reduction in S_MOD, then each probe passes S_PROBE and S_LOOK and,
// on a search hit of the stored length, compares key characters one at a time
// through S_CMPRD and S_CMP (one character memory port); inserts copy in S_WRITE
// throughput: one key at a time; characters one per cycle unless a result waits
// reset: slot-used bits, counters and hash clear at once, no clearing pass
module string_hash_table_quadratic_probe_top #(
  parameter int unsigned TableDepth = shtqp_pkg::TableDepth,
  parameter int unsigned KeyChars   = shtqp_pkg::KeyChars
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [shtqp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [shtqp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             operation_i,
  input  logic [shtqp_pkg::CharW-1:0]      key_char_i,
  input  logic                             last_char_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [shtqp_pkg::SlotW-1:0]      slot_index_o,
  output logic [shtqp_pkg::StatW-1:0]      status_o
);

  localparam int unsigned SlotAW = $clog2(TableDepth);
  localparam int unsigned DenW   = $clog2(TableDepth + 1);
  localparam int unsigned KeyAW  = (KeyChars > 1) ? $clog2(KeyChars) : 1;
  localparam int unsigned LenW   = $clog2(KeyChars + 1);
  localparam int unsigned CharAW = $clog2(TableDepth * KeyChars);
  localparam int unsigned CW     = shtqp_pkg::CharW;

  localparam logic [3:0] S_CHAR  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_PROBE = 4'd2;
  localparam logic [3:0] S_LOOK  = 4'd3;
  localparam logic [3:0] S_CMPRD = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_WRITE = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [shtqp_pkg::SizeW-1:0] tsize_q;
  logic [shtqp_pkg::MultW-1:0] mult_q;

  // memories
  logic [CW-1:0]   chars_mem [TableDepth*KeyChars];
  logic [LenW-1:0] len_mem   [TableDepth];
  logic [CW-1:0]   key_mem   [KeyChars];
  logic [TableDepth-1:0] used_q;

  logic [3:0]        st_q, st_d;
  logic [shtqp_pkg::HashW-1:0] hash_q, hash_d;
  logic [LenW-1:0]   cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              op_q, op_d;
  logic [DenW-1:0]   size_q, size_d;
  logic [SlotAW-1:0] home_q, home_d;
  logic [DenW-1:0]   off_q, off_d;
  logic [DenW-1:0]   pi_q, pi_d;
  logic [SlotAW-1:0] slot_q, slot_d;
  logic [LenW-1:0]   j_q, j_d;
  logic              res_v_q, res_v_d;
  logic [shtqp_pkg::SlotW-1:0] res_slot_q, res_slot_d;
  logic [shtqp_pkg::StatW-1:0] res_st_q, res_st_d;

  logic              mod_start, mod_done;
  logic [DenW-1:0]   mod_rem;

  // memory ports
  logic              key_we;
  logic [KeyAW-1:0]  key_waddr, key_raddr;
  logic [CW-1:0]     key_rd_q;
  logic              ch_we;
  logic [CharAW-1:0] ch_addr;
  logic [CW-1:0]     ch_rd_q;
  logic              len_we;
  logic [LenW-1:0]   len_rd_q;
  logic              used_rd;

  logic              acc;
  logic [shtqp_pkg::HashW-1:0] hash_new;
  logic [DenW:0]     off_sum, slot_sum;
  logic [DenW-1:0]   off_nx, slot_nx;
  logic [CharAW-1:0] slot_base;

  assign in_ready_o   = (st_q == S_CHAR) && !res_v_q;
  assign acc          = in_valid_i && in_ready_o;
  assign out_valid_o  = res_v_q;
  assign slot_index_o = res_slot_q;
  assign status_o     = res_st_q;
  assign hash_new     = shtqp_pkg::HashW'(hash_q * mult_q) + shtqp_pkg::HashW'(key_char_i);
  assign used_rd      = used_q[slot_q];
  assign slot_base    = CharAW'(slot_q) * CharAW'(KeyChars);

  // triangular offset and slot for the current probe, both kept below size
  always_comb begin
    off_sum = {1'b0, off_q} + {1'b0, pi_q};
    off_nx  = (off_sum >= {1'b0, size_q}) ? DenW'(off_sum - {1'b0, size_q})
                                          : off_sum[DenW-1:0];
    slot_sum = (DenW+1)'(home_q) + {1'b0, off_nx};
    slot_nx  = (slot_sum >= {1'b0, size_q}) ? DenW'(slot_sum - {1'b0, size_q})
                                            : slot_sum[DenW-1:0];
  end

  shtqp_mod #(
    .NumW(shtqp_pkg::HashW),
    .DenW(DenW)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .num_i  (hash_q),
    .den_i  (size_q),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  always_comb begin
    st_d       = st_q;
    hash_d     = hash_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    op_d       = op_q;
    size_d     = size_q;
    home_d     = home_q;
    off_d      = off_q;
    pi_d       = pi_q;
    slot_d     = slot_q;
    j_d        = j_q;
    res_v_d    = res_v_q;
    res_slot_d = res_slot_q;
    res_st_d   = res_st_q;
    mod_start  = 1'b0;
    key_we     = 1'b0;
    key_waddr  = cnt_q[KeyAW-1:0];
    key_raddr  = j_q[KeyAW-1:0];
    ch_we      = 1'b0;
    ch_addr    = slot_base + CharAW'(j_q);
    len_we     = 1'b0;
    if (res_v_q && out_ready_i) begin
      res_v_d = 1'b0;
    end
    unique case (st_q)
      S_CHAR: begin
        if (acc) begin
          hash_d = hash_new;
          if (cnt_q < LenW'(KeyChars)) begin
            key_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_char_i) begin
            op_d = operation_i;
            if (tsize_q == '0) begin
              size_d = DenW'(1);
            end else if (32'(tsize_q) > 32'(TableDepth)) begin
              size_d = DenW'(TableDepth);
            end else begin
              size_d = DenW'(tsize_q);
            end
            if (ovf_q || (cnt_q >= LenW'(KeyChars))) begin
              res_v_d    = 1'b1;
              res_slot_d = '0;
              res_st_d   = shtqp_pkg::StTooLong;
              st_d       = S_OUT;
            end else begin
              st_d = S_MOD;
            end
          end
        end
      end
      S_MOD: begin
        // start is issued once from the registered hash, then wait
        if (!mod_done) begin
          mod_start = (pi_q == '1);
          pi_d      = '0;
        end else begin
          home_d = SlotAW'(mod_rem);
          off_d  = '0;
          pi_d   = '0;
          st_d   = S_PROBE;
        end
      end
      S_PROBE: begin
        if (pi_q == size_q) begin
          res_v_d    = 1'b1;
          res_slot_d = '0;
          res_st_d   = (op_q == shtqp_pkg::OpInsert) ? shtqp_pkg::StFull
                                                     : shtqp_pkg::StNotFound;
          st_d       = S_OUT;
        end else begin
          off_d  = off_nx;
          slot_d = SlotAW'(slot_nx);
          pi_d   = pi_q + 1'b1;
          j_d    = '0;
          st_d   = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!used_rd) begin
          if (op_q == shtqp_pkg::OpInsert) begin
            st_d = S_WRITE;
          end else begin
            res_v_d    = 1'b1;
            res_slot_d = '0;
            res_st_d   = shtqp_pkg::StNotFound;
            st_d       = S_OUT;
          end
        end else if (op_q == shtqp_pkg::OpInsert) begin
          st_d = S_PROBE;
        end else if (len_rd_q != cnt_q) begin
          st_d = S_PROBE;
        end else if (cnt_q == '0) begin
          res_v_d    = 1'b1;
          res_slot_d = shtqp_pkg::SlotW'(slot_q);
          res_st_d   = shtqp_pkg::StFound;
          st_d       = S_OUT;
        end else begin
          st_d = S_CMPRD;
        end
      end
      S_CMPRD: begin
        // memories read address j this cycle
        st_d = S_CMP;
      end
      S_CMP: begin
        if (ch_rd_q != key_rd_q) begin
          st_d = S_PROBE;
        end else if (j_q + 1'b1 == cnt_q) begin
          res_v_d    = 1'b1;
          res_slot_d = shtqp_pkg::SlotW'(slot_q);
          res_st_d   = shtqp_pkg::StFound;
          st_d       = S_OUT;
        end else begin
          j_d  = j_q + 1'b1;
          st_d = S_CMPRD;
        end
      end
      S_WRITE: begin
        // copy the key: key memory read of j lands in the next cycle
        if (j_q != '0) begin
          ch_we   = 1'b1;
          ch_addr = slot_base + CharAW'(j_q - 1'b1);
        end
        if (j_q == cnt_q) begin
          len_we     = 1'b1;
          res_v_d    = 1'b1;
          res_slot_d = shtqp_pkg::SlotW'(slot_q);
          res_st_d   = shtqp_pkg::StInserted;
          st_d       = S_OUT;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_OUT: begin
        hash_d = '0;
        cnt_d  = '0;
        ovf_d  = 1'b0;
        pi_d   = '1;
        st_d   = S_CHAR;
      end
      default: st_d = S_CHAR;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_char_i;
    end
    key_rd_q <= key_mem[key_raddr];
    if (ch_we) begin
      chars_mem[ch_addr] <= key_rd_q;
    end
    ch_rd_q <= chars_mem[ch_addr];
    if (len_we) begin
      len_mem[slot_q] <= cnt_q;
    end
    len_rd_q <= len_mem[SlotAW'(slot_nx)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q <= shtqp_pkg::SizeW'(64);
      mult_q  <= shtqp_pkg::MultW'(31);
      used_q  <= '0;
      st_q    <= S_CHAR;
      hash_q  <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      pi_q    <= '1;
      res_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          shtqp_pkg::CfgTableSize: tsize_q <= cfg_data_i[shtqp_pkg::SizeW-1:0];
          shtqp_pkg::CfgHashMult:  mult_q  <= cfg_data_i[shtqp_pkg::MultW-1:0];
          default: ;
        endcase
      end
      if (len_we) begin
        used_q[slot_q] <= 1'b1;
      end
      st_q    <= st_d;
      hash_q  <= hash_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      pi_q    <= pi_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    size_q     <= size_d;
    home_q     <= home_d;
    off_q      <= off_d;
    slot_q     <= slot_d;
    j_q        <= j_d;
    res_slot_q <= res_slot_d;
    res_st_q   <= res_st_d;
  end

endmodule

/* sim/string_hash_table_quadratic_probe_checker.sv */
`timescale 1ns / 1ps

module string_hash_table_quadratic_probe_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [shtqp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [shtqp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           operation_i,
  input  logic [shtqp_pkg::CharW-1:0]    key_char_i,
  input  logic                           last_char_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [shtqp_pkg::SlotW-1:0]    slot_index_i,
  input  logic [shtqp_pkg::StatW-1:0]    status_i,
  output int                             err_count_o,
  output int                             pending_o
);

  typedef struct packed {
    logic [shtqp_pkg::SlotW-1:0] slot;
    logic [shtqp_pkg::StatW-1:0] stat;
  } lookup_t;

  lookup_t lookup_q[$];

  logic [shtqp_pkg::SizeW-1:0] size_q;
  logic [shtqp_pkg::MultW-1:0] mult_q;
  logic [shtqp_pkg::CharW-1:0] slot_chars[shtqp_pkg::TableDepth][shtqp_pkg::KeyChars];
  int unsigned                 slot_len[shtqp_pkg::TableDepth];
  logic                        slot_used[shtqp_pkg::TableDepth];
  logic [shtqp_pkg::CharW-1:0] key_buf[shtqp_pkg::KeyChars];
  int unsigned                 key_len;
  logic [shtqp_pkg::HashW-1:0] key_hash;
  logic                        key_ovf;

  assign pending_o = lookup_q.size();

  function automatic lookup_t probe_table(logic op);
    int unsigned size, home, off, s;
    lookup_t     r;
    bit          done, same;
    size = (size_q == 0) ? 1 : (size_q > shtqp_pkg::TableDepth) ? shtqp_pkg::TableDepth
                                                                 : size_q;
    home = key_hash % size;
    r.slot = '0;
    if (key_ovf) begin
      r.stat = shtqp_pkg::StTooLong;
      return r;
    end
    r.stat = (op == shtqp_pkg::OpInsert) ? shtqp_pkg::StFull : shtqp_pkg::StNotFound;
    off = 0;
    done = 0;
    for (int unsigned i = 0; i < size && !done; i++) begin
      off = (off + i) % size;
      s = (home + off) % size;
      if (op == shtqp_pkg::OpInsert) begin
        if (!slot_used[s]) begin
          for (int j = 0; j < key_len; j++) slot_chars[s][j] = key_buf[j];
          slot_len[s] = key_len;
          slot_used[s] = 1'b1;
          r.slot = s[shtqp_pkg::SlotW-1:0];
          r.stat = shtqp_pkg::StInserted;
          done = 1;
        end
      end else if (!slot_used[s]) begin
        done = 1;
      end else begin
        same = (slot_len[s] == key_len);
        for (int j = 0; j < key_len && same; j++) same = (slot_chars[s][j] == key_buf[j]);
        if (same) begin
          r.slot = s[shtqp_pkg::SlotW-1:0];
          r.stat = shtqp_pkg::StFound;
          done = 1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      size_q = shtqp_pkg::TableDepth;
      mult_q = 31;
      for (int i = 0; i < shtqp_pkg::TableDepth; i++) slot_used[i] = 1'b0;
      key_len = 0;
      key_hash = '0;
      key_ovf = 1'b0;
      err_count_o = 0;
      lookup_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == shtqp_pkg::CfgTableSize) begin
          size_q = cfg_data_i[shtqp_pkg::SizeW-1:0];
        end else if (cfg_idx_i == shtqp_pkg::CfgHashMult) begin
          mult_q = cfg_data_i[shtqp_pkg::MultW-1:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        key_hash = key_hash * mult_q + key_char_i;
        if (key_len < shtqp_pkg::KeyChars) begin
          key_buf[key_len] = key_char_i;
          key_len++;
        end else begin
          key_ovf = 1'b1;
        end
        if (last_char_i) begin
          lookup_q.push_back(probe_table(operation_i));
          key_len = 0;
          key_hash = '0;
          key_ovf = 1'b0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (lookup_q.size() == 0) begin
          err_count_o++;
          if (err_count_o <= 10)
            $display("unexpected result: slot %0d status %0d", slot_index_i, status_i);
        end else begin
          want = lookup_q.pop_front();
          if (want.slot !== slot_index_i || want.stat !== status_i) begin
            err_count_o++;
            if (err_count_o <= 10)
              $display("mismatch: expected slot %0d status %0d, got slot %0d status %0d",
                       want.slot, want.stat, slot_index_i, status_i);
          end
        end
      end
    end
  end

endmodule

/* sim/string_hash_table_quadratic_probe_top_tb.sv */
`timescale 1ns / 1ps

module string_hash_table_quadratic_probe_top_tb;

  localparam int CycleLimit = 20000000;
  localparam int Settle = 400;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [shtqp_pkg::CfgIdxW-1:0]  cfg_idx_i = shtqp_pkg::CfgTableSize;
  logic [shtqp_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic                           operation_i = shtqp_pkg::OpInsert;
  logic [shtqp_pkg::CharW-1:0]    key_char_i = '0;
  logic                           last_char_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [shtqp_pkg::SlotW-1:0]    slot_index_o;
  logic [shtqp_pkg::StatW-1:0]    status_o;

  int err_count, pending, cycles, sent;
  bit tx_idle = 1, rx_idle = 1, hold_req = 0;
  int hold_cnt = 0;

  // bank of keys already sent for insert, reused for searches
  logic [shtqp_pkg::CharW-1:0] bank_chars[128][24];
  int                          bank_len[128];
  int                          bank_n = 0;
  logic [shtqp_pkg::CharW-1:0] cur[24];
  int                          cur_len;

  always #10 clk_i = ~clk_i;

  string_hash_table_quadratic_probe_top dut (.*);

  string_hash_table_quadratic_probe_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .key_char_i, .last_char_i,
    .out_valid_i(out_valid_o), .out_ready_i, .slot_index_i(slot_index_o),
    .status_i(status_o), .err_count_o(err_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("string_hash_table_quadratic_probe_top_tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      out_ready_i <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= 600) begin
        hold_req = 0;
        hold_cnt = 0;
      end
    end else begin
      out_ready_i <= !(rx_idle && $urandom_range(99) < 29);
    end
  end

  task automatic send_char(logic op, logic [shtqp_pkg::CharW-1:0] c, logic last);
    @(negedge clk_i);
    while (tx_idle && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    key_char_i <= c;
    last_char_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // mixed_op: early characters carry the other operation code
  task automatic send_key(logic op, bit mixed_op = 0);
    for (int i = 0; i < cur_len; i++)
      send_char((mixed_op && i < cur_len - 1) ? !op : op, cur[i], i == cur_len - 1);
    if (op == shtqp_pkg::OpInsert && bank_n < 128) begin
      for (int i = 0; i < cur_len; i++) bank_chars[bank_n][i] = cur[i];
      bank_len[bank_n] = cur_len;
      bank_n++;
    end
  endtask

  task automatic make_key(int len, int alpha);
    cur_len = len;
    for (int i = 0; i < len; i++)
      case (alpha)
        0: cur[i] = $urandom_range(3);
        1: cur[i] = $urandom_range(127, 120);
        default: cur[i] = $urandom_range(127);
      endcase
  endtask

  task automatic random_key();
    int len, k;
    logic op;
    op = $urandom_range(1) ? shtqp_pkg::OpSearch : shtqp_pkg::OpInsert;
    if (op == shtqp_pkg::OpSearch && bank_n > 0 && $urandom_range(99) < 60) begin
      k = $urandom_range(bank_n - 1);
      cur_len = bank_len[k];
      for (int i = 0; i < cur_len; i++) cur[i] = bank_chars[k][i];
    end else begin
      len = ($urandom_range(99) < 6) ? $urandom_range(24, 18) : $urandom_range(6, 1);
      make_key(len, $urandom_range(2));
    end
    send_key(op);
  endtask

  task automatic write_cfg(logic [shtqp_pkg::CfgIdxW-1:0] idx,
                           logic [shtqp_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic set_table(int size, logic [shtqp_pkg::MultW-1:0] mult);
    drain();
    write_cfg(shtqp_pkg::CfgTableSize, size);
    write_cfg(shtqp_pkg::CfgHashMult, mult);
  endtask

  initial begin
    logic [shtqp_pkg::CfgDataW-1:0] sizes[6] = '{64, 0, 1, 127, 5, 64};
    logic [shtqp_pkg::CfgDataW-1:0] mults[6];
    mults = '{31, 0, 32'hFFFF_FFFF, 7, 31, $urandom};
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: single chars, extreme codes, 20 and 21 character keys
    cur_len = 1; cur[0] = 7'd65;
    send_key(shtqp_pkg::OpInsert);
    send_key(shtqp_pkg::OpSearch);
    cur[0] = 7'd66;
    send_key(shtqp_pkg::OpSearch);
    cur_len = 3; cur[0] = 7'd0; cur[1] = 7'd127; cur[2] = 7'd0;
    send_key(shtqp_pkg::OpInsert);
    send_key(shtqp_pkg::OpSearch);
    send_key(shtqp_pkg::OpSearch, 1);
    make_key(20, 2);
    send_key(shtqp_pkg::OpInsert);
    send_key(shtqp_pkg::OpSearch);
    make_key(21, 1);
    send_key(shtqp_pkg::OpInsert);
    send_key(shtqp_pkg::OpSearch);
    make_key(20, 0);
    send_key(shtqp_pkg::OpSearch);

    // one-slot table: full on insert, probes exhausted on search
    set_table(1, 31);
    cur_len = 2; cur[0] = 7'd1; cur[1] = 7'd2;
    send_key(shtqp_pkg::OpInsert);
    send_key(shtqp_pkg::OpInsert);
    cur[1] = 7'd3;
    send_key(shtqp_pkg::OpSearch);

    for (int p = 0; p < 6; p++) begin
      set_table(sizes[p], mults[p]);
      tx_idle = (p != 3);
      rx_idle = (p != 3);
      if (p == 1) hold_req = 1;
      while (sent < 40 + (p + 1) * 110) random_key();
    end

    drain();
    if (err_count == 0) begin
      $display("string_hash_table_quadratic_probe_top_tb: clean");
    end else begin
      $display("string_hash_table_quadratic_probe_top_tb: errors");
    end
    $finish;
  end

endmodule
